@@ hw/rtl/c2vr_pkg.sv @@
// Shared constants, types and register codes of the 2-D valid convolution block.
// No dependencies; every other file of the block refers to it by scoped names.
package c2vr_pkg;

  // Sizing of the image, kernel and samples.
  localparam int MaxWidth   = 256;
  localparam int MaxKernel  = 4;
  localparam int SampleBits = 16;

  // Coefficients are Q8.8 and four of them pack into one 64-bit row register.
  localparam int CoefBits     = 16;
  localparam int KrowBits     = 64;
  localparam int KregRows     = 4;
  localparam int KCap         = (MaxKernel < KregRows) ? MaxKernel : KregRows;
  localparam int KIdxBits     = (KCap > 1) ? $clog2(KCap) : 1;
  localparam int LsRows       = (MaxKernel > 1) ? MaxKernel - 1 : 1;

  // Counter and register widths.
  localparam int ColBits      = $clog2(MaxWidth);
  localparam int CntBits      = ColBits + 1;
  localparam int SizeBits     = 9;
  localparam int KsBits       = 3;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 64;

  // Arithmetic widths.
  localparam int ProdBits     = SampleBits + CoefBits;
  localparam int RowSumBits   = ProdBits + $clog2(MaxKernel);
  localparam int SumBits      = ProdBits + $clog2(MaxKernel * MaxKernel);
  localparam int FracBits     = 8;
  localparam int ActBits      = 15;
  localparam int ActMax       = 2 ** ActBits - 1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [CoefBits-1:0]   coef_t;
  typedef sample_t [MaxKernel-1:0][MaxKernel-1:0] window_t;
  typedef coef_t   [KCap-1:0][KCap-1:0]           coef_mat_t;
  typedef sample_t [LsRows-1:0]                   line_t;

  // Flags that travel with an item down the arithmetic pipeline.
  typedef struct packed {
    logic prod;
    logic last;
  } tag_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    RegImageSize  = 3'd0,
    RegKernelSize = 3'd1,
    RegKernelRow0 = 3'd2,
    RegKernelRow1 = 3'd3,
    RegKernelRow2 = 3'd4,
    RegKernelRow3 = 3'd5
  } cfg_reg_e;

endpackage

@@ hw/rtl/c2vr_if.sv @@
// Valid/ready channel interfaces of the convolution block: pixel input,
// activation output and configuration write. Depends on c2vr_pkg.
interface c2vr_pix_if;
  logic                                valid;
  logic                                ready;
  logic signed [c2vr_pkg::SampleBits-1:0] pixel;
  logic                                frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface c2vr_act_if;
  logic                           valid;
  logic                           ready;
  logic [c2vr_pkg::ActBits-1:0]   activation;
  logic                           last_of_frame;

  modport source (output valid, output activation, output last_of_frame, input ready);
  modport sink   (input valid, input activation, input last_of_frame, output ready);
endinterface

interface c2vr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [c2vr_pkg::CfgIdxBits-1:0]   index;
  logic [c2vr_pkg::CfgDataBits-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/c2vr_mac.sv @@
// Window multiply-accumulate pipeline with ReLU and saturation.
// Depends on c2vr_pkg; instantiated by conv2d_valid_relu.
module c2vr_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  c2vr_pkg::tag_t                tag_i,
  input  c2vr_pkg::window_t             win_i,
  input  c2vr_pkg::coef_mat_t           coef_i,
  input  logic [c2vr_pkg::KsBits-1:0]   ksize_i,
  output c2vr_pkg::tag_t                tag_o,
  output logic [c2vr_pkg::ActBits-1:0]  act_o
);

  localparam int MK = c2vr_pkg::MaxKernel;

  typedef logic signed [c2vr_pkg::ProdBits-1:0]   prod_t;
  typedef logic signed [c2vr_pkg::RowSumBits-1:0] rsum_t;
  typedef logic signed [c2vr_pkg::SumBits-1:0]    sum_t;

  prod_t [MK-1:0][MK-1:0] prod_d, prod_q;
  rsum_t [MK-1:0]         rsum_d, rsum_q;
  sum_t                   sum_d, sum_q;
  c2vr_pkg::tag_t         t3_q, t4_q, t5_q;

  // One product per window place; places outside the active kernel give zero.
  always_comb begin
    int                              base;
    logic                            in_kernel;
    logic [c2vr_pkg::KIdxBits-1:0]   kr;
    logic [c2vr_pkg::KIdxBits-1:0]   kc;
    prod_t                           p;
    base = MK - int'(ksize_i);
    for (int wr = 0; wr < MK; wr++) begin
      for (int wc = 0; wc < MK; wc++) begin
        in_kernel = (wr >= base) && (wc >= base);
        kr = c2vr_pkg::KIdxBits'(wr - base);
        kc = c2vr_pkg::KIdxBits'(wc - base);
        p = win_i[wr][wc] * coef_i[kr][kc];
        prod_d[wr][wc] = in_kernel ? p : '0;
      end
    end
  end

  // First adder level: one sum per window row.
  always_comb begin
    rsum_t acc;
    for (int r = 0; r < MK; r++) begin
      acc = '0;
      for (int c = 0; c < MK; c++) begin
        acc = acc + c2vr_pkg::RowSumBits'(prod_q[r][c]);
      end
      rsum_d[r] = acc;
    end
  end

  // Second adder level: total over the rows.
  always_comb begin
    sum_t acc;
    acc = '0;
    for (int r = 0; r < MK; r++) begin
      acc = acc + c2vr_pkg::SumBits'(rsum_q[r]);
    end
    sum_d = acc;
  end

  // Pipeline registers; the tags mark which slots carry a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_q <= '0;
      t4_q <= '0;
      t5_q <= '0;
    end else if (adv_i) begin
      t3_q <= tag_i;
      t4_q <= t3_q;
      t5_q <= t4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      rsum_q <= rsum_d;
      sum_q  <= sum_d;
    end
  end

  // Drop the fraction, clamp negatives to zero and saturate the top.
  always_comb begin
    sum_t sh;
    sh = sum_q >>> c2vr_pkg::FracBits;
    if (sum_q <= 0) begin
      act_o = '0;
    end else if (sh > c2vr_pkg::SumBits'(c2vr_pkg::ActMax)) begin
      act_o = c2vr_pkg::ActBits'(c2vr_pkg::ActMax);
    end else begin
      act_o = c2vr_pkg::ActBits'(sh);
    end
  end

  assign tag_o = t5_q;

endmodule

@@ hw/rtl/conv2d_valid_relu.sv @@
// Top level of the streaming 2-D valid convolution with ReLU.
// Depends on c2vr_pkg, the channel interfaces in c2vr_if and c2vr_mac.

// The block accepts one pixel per clock in raster order while not stalled and
// returns one activation for every position where a full kernel window fits,
// so a frame of N x N pixels with a K x K kernel gives (N-K+1) squared results.
// An activation passes the line-store read, the window update and write-back,
// the multipliers and two adder levels, and then enters the output register.
// The line store is a single memory read and written once per pixel; a pixel
// whose column matches the previous write picks up the written data from a
// bypass register. Input stalls only while a result waits at the output and
// the item at the end of the pipeline also carries one. The line store needs
// no clearing after reset: every entry is written before it feeds the active
// kernel. The user must write configuration only while no item is in flight;
// the block itself does not enforce it.
module conv2d_valid_relu (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2vr_cfg_if.sink    cfg_i,
  c2vr_pix_if.sink    pix_i,
  c2vr_act_if.source  act_o
);

  localparam int MK = c2vr_pkg::MaxKernel;
  localparam int CB = c2vr_pkg::CntBits;
  localparam logic [c2vr_pkg::SizeBits-1:0] ImageSizeReset  = 9'd28;
  localparam logic [c2vr_pkg::KsBits-1:0]   KernelSizeReset = 3'd3;

  // Configuration registers.
  logic [c2vr_pkg::SizeBits-1:0] image_size_q;
  logic [c2vr_pkg::KsBits-1:0]   kernel_size_q;
  logic [c2vr_pkg::KrowBits-1:0] kernel_row_q [c2vr_pkg::KregRows];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q  <= ImageSizeReset;
      kernel_size_q <= KernelSizeReset;
      for (int r = 0; r < c2vr_pkg::KregRows; r++) begin
        kernel_row_q[r] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        c2vr_pkg::RegImageSize:  image_size_q    <= cfg_i.data[c2vr_pkg::SizeBits-1:0];
        c2vr_pkg::RegKernelSize: kernel_size_q   <= cfg_i.data[c2vr_pkg::KsBits-1:0];
        c2vr_pkg::RegKernelRow0: kernel_row_q[0] <= cfg_i.data;
        c2vr_pkg::RegKernelRow1: kernel_row_q[1] <= cfg_i.data;
        c2vr_pkg::RegKernelRow2: kernel_row_q[2] <= cfg_i.data;
        c2vr_pkg::RegKernelRow3: kernel_row_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Effective sizes: out-of-range settings clamp to the supported range.
  logic [CB-1:0]                 n_eff;
  logic [c2vr_pkg::KsBits-1:0]   k_eff;
  c2vr_pkg::coef_mat_t           coef_mat;

  always_comb begin
    int n_int;
    int k_int;
    n_int = int'(image_size_q);
    k_int = int'(kernel_size_q);
    if (n_int < 1) n_int = 1;
    if (n_int > c2vr_pkg::MaxWidth) n_int = c2vr_pkg::MaxWidth;
    if (k_int < 1) k_int = 1;
    if (k_int > c2vr_pkg::KCap) k_int = c2vr_pkg::KCap;
    n_eff = CB'(n_int);
    k_eff = c2vr_pkg::KsBits'(k_int);
    for (int r = 0; r < c2vr_pkg::KCap; r++) begin
      for (int c = 0; c < c2vr_pkg::KCap; c++) begin
        coef_mat[r][c] = kernel_row_q[r][c2vr_pkg::CoefBits*c +: c2vr_pkg::CoefBits];
      end
    end
  end

  // Pipeline control.
  c2vr_pkg::tag_t mac_tag;
  logic [c2vr_pkg::ActBits-1:0] mac_act;
  logic out_valid_q;
  logic advance;
  logic accept;

  assign advance     = !(mac_tag.prod && out_valid_q && !act_o.ready);
  assign accept      = pix_i.valid && advance;
  assign pix_i.ready = advance;

  // Position of the incoming pixel, with wrap for frame overrun and size change.
  logic [c2vr_pkg::ColBits-1:0] col_q, row_q, col_d, row_d;
  logic [c2vr_pkg::ColBits-1:0] acc_col, acc_row;
  c2vr_pkg::tag_t               acc_tag;

  always_comb begin
    logic [CB-1:0] c0;
    logic [CB-1:0] r0;
    logic [CB-1:0] cn;
    logic [CB-1:0] rn;
    logic [CB-1:0] kx;
    c0 = pix_i.frame_start ? '0 : CB'(col_q);
    r0 = pix_i.frame_start ? '0 : CB'(row_q);
    if (c0 >= n_eff) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= n_eff) begin
      r0 = '0;
    end
    acc_col = c0[c2vr_pkg::ColBits-1:0];
    acc_row = r0[c2vr_pkg::ColBits-1:0];
    kx = CB'(k_eff);
    acc_tag.prod = (kx <= n_eff) && (r0 + 1'b1 >= kx) && (c0 + 1'b1 >= kx);
    acc_tag.last = (r0 + 1'b1 == n_eff) && (c0 + 1'b1 == n_eff);
    // Advance to the next position.
    cn = c0 + 1'b1;
    rn = r0;
    if (cn >= n_eff) begin
      cn = '0;
      rn = r0 + 1'b1;
      if (rn >= n_eff) begin
        rn = '0;
      end
    end
    col_d = cn[c2vr_pkg::ColBits-1:0];
    row_d = rn[c2vr_pkg::ColBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: accepted pixel waits for its line-store read.
  logic                         s1_valid_q;
  c2vr_pkg::tag_t               s1_tag_q;
  c2vr_pkg::sample_t            s1_pix_q;
  logic [c2vr_pkg::ColBits-1:0] s1_col_q;
  c2vr_pkg::tag_t               s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_tag_q   <= '0;
      s2_tag_q   <= '0;
    end else if (advance) begin
      s1_valid_q <= accept;
      s1_tag_q   <= acc_tag;
      s2_tag_q   <= s1_valid_q ? s1_tag_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pix_i.pixel;
      s1_col_q <= acc_col;
    end
  end

  // Line store: one entry per column holding the previous rows.
  c2vr_pkg::line_t line_mem [c2vr_pkg::MaxWidth];
  c2vr_pkg::line_t rd_q;
  c2vr_pkg::line_t ls_line;
  c2vr_pkg::line_t wr_line;
  logic            ls_we;
  logic            fwd_valid_q;
  logic [c2vr_pkg::ColBits-1:0] fwd_addr_q;
  c2vr_pkg::line_t fwd_data_q;
  logic            fwd_hit;

  assign ls_we   = advance && s1_valid_q;
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_col_q);
  assign ls_line = fwd_hit ? fwd_data_q : rd_q;

  always_comb begin
    for (int r = 0; r + 1 < c2vr_pkg::LsRows; r++) begin
      wr_line[r] = ls_line[r+1];
    end
    wr_line[c2vr_pkg::LsRows-1] = s1_pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[acc_col];
    end
    if (ls_we) begin
      line_mem[s1_col_q] <= wr_line;
    end
  end

  // The last written entry bypasses a read that raced with its write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ls_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      fwd_addr_q <= s1_col_q;
      fwd_data_q <= wr_line;
    end
  end

  // Sliding window: shift one column left, new column from the line store.
  c2vr_pkg::window_t window_q, window_d;

  always_comb begin
    for (int r = 0; r < MK; r++) begin
      for (int c = 0; c + 1 < MK; c++) begin
        window_d[r][c] = window_q[r][c+1];
      end
    end
    for (int r = 0; r + 1 < MK; r++) begin
      window_d[r][MK-1] = ls_line[r];
    end
    window_d[MK-1][MK-1] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (ls_we) begin
      window_q <= window_d;
    end
  end

  // Multiply-accumulate and activation.
  c2vr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (advance),
    .tag_i   (s2_tag_q),
    .win_i   (window_q),
    .coef_i  (coef_mat),
    .ksize_i (k_eff),
    .tag_o   (mac_tag),
    .act_o   (mac_act)
  );

  // Output register.
  logic [c2vr_pkg::ActBits-1:0] out_act_q;
  logic                         out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && mac_tag.prod) begin
      out_valid_q <= 1'b1;
    end else if (act_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && mac_tag.prod) begin
      out_act_q  <= mac_act;
      out_last_q <= mac_tag.last;
    end
  end

  assign act_o.valid         = out_valid_q;
  assign act_o.activation    = out_act_q;
  assign act_o.last_of_frame = out_last_q;

  // An accepted pixel is in stage 1 on the next cycle.
  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel missing from stage 1");

  // A line-store write stays inside the current image width.
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ls_we |-> (CB'(s1_col_q) < n_eff))
    else $error("line-store write beyond image width");

  // The last pixel of a frame always completes a window when the kernel fits.
  a_last_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_tag_q.last && (CB'(k_eff) <= n_eff)) |-> s1_tag_q.prod)
    else $error("last pixel of frame without a result");

  // A result leaving the pipeline lands in the output register.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && mac_tag.prod) |=> out_valid_q)
    else $error("result lost at the output register");

endmodule

@@ test/conv2d_valid_relu_tb.sv @@
// Self-checking testbench for conv2d_valid_relu: streams pixel frames, predicts
// every activation in a cycle-free model of the convolution and compares them.
// Depends on c2vr_pkg, the channel interfaces of c2vr_if and the block itself.
module conv2d_valid_relu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeLatency   = 5;
  localparam int SettleCycles  = 2 * PipeLatency;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 5000;
  localparam int RandomItems   = 1300;

  typedef struct {
    c2vr_pkg::sample_t pixel;
    logic              frame_start;
  } pix_item_t;

  typedef struct {
    logic [c2vr_pkg::ActBits-1:0] activation;
    logic                         last;
  } act_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  c2vr_cfg_if cfg_if ();
  c2vr_pix_if pix_if ();
  c2vr_act_if act_if ();

  conv2d_valid_relu u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .act_o  (act_if)
  );

  // Configuration and state of the convolution predictor.
  logic [c2vr_pkg::SizeBits-1:0] img_side_reg;
  logic [c2vr_pkg::KsBits-1:0]   krn_side_reg;
  logic [c2vr_pkg::KrowBits-1:0] krow_reg [c2vr_pkg::KregRows];
  c2vr_pkg::sample_t             line_mem [c2vr_pkg::MaxWidth][c2vr_pkg::LsRows];
  c2vr_pkg::sample_t             win [c2vr_pkg::MaxKernel][c2vr_pkg::MaxKernel];
  int unsigned                   col_cnt;
  int unsigned                   row_cnt;

  pix_item_t pixel_q [$];
  act_item_t act_q [$];

  int err_cnt       = 0;
  int pix_pushed    = 0;
  int pix_accepted  = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int stuck_cycles  = 0;
  bit pix_taken     = 1'b0;

  always begin
    #2;
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
  end

  task automatic report(input string what);
    err_cnt++;
    $display("[%0t] ERROR %s", $time, what);
  endtask

  // Register write as seen by the predictor.
  task automatic apply_cfg(input c2vr_pkg::cfg_reg_e idx,
                           input logic [c2vr_pkg::CfgDataBits-1:0] d);
    case (idx)
      c2vr_pkg::RegImageSize:  img_side_reg = d[c2vr_pkg::SizeBits-1:0];
      c2vr_pkg::RegKernelSize: krn_side_reg = d[c2vr_pkg::KsBits-1:0];
      c2vr_pkg::RegKernelRow0: krow_reg[0] = d;
      c2vr_pkg::RegKernelRow1: krow_reg[1] = d;
      c2vr_pkg::RegKernelRow2: krow_reg[2] = d;
      c2vr_pkg::RegKernelRow3: krow_reg[3] = d;
      default: ;
    endcase
  endtask

  // One accepted pixel: advance the position, slide the window, update the line
  // store and queue the activation if a full kernel window ends here.
  task automatic conv_step(input c2vr_pkg::sample_t px, input logic fs);
    int unsigned       n, k, col, row, base;
    int                r, c;
    longint            acc;
    c2vr_pkg::coef_t   cf;
    act_item_t         res;
    n = img_side_reg;
    if (n < 1) n = 1;
    if (n > c2vr_pkg::MaxWidth) n = c2vr_pkg::MaxWidth;
    k = krn_side_reg;
    if (k < 1) k = 1;
    if (k > c2vr_pkg::KCap) k = c2vr_pkg::KCap;

    if (fs) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    // A size that shrank under a running frame wraps the position.
    if (col_cnt >= n) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= n) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;

    for (r = 0; r < c2vr_pkg::MaxKernel; r++) begin
      for (c = 0; c < c2vr_pkg::MaxKernel - 1; c++) win[r][c] = win[r][c+1];
    end
    for (r = 0; r < c2vr_pkg::MaxKernel - 1; r++) begin
      win[r][c2vr_pkg::MaxKernel-1] = line_mem[col][r];
    end
    win[c2vr_pkg::MaxKernel-1][c2vr_pkg::MaxKernel-1] = px;
    for (r = 0; r < c2vr_pkg::LsRows - 1; r++) line_mem[col][r] = line_mem[col][r+1];
    line_mem[col][c2vr_pkg::LsRows-1] = px;

    if (k <= n && row + 1 >= k && col + 1 >= k) begin
      acc  = 0;
      base = c2vr_pkg::MaxKernel - k;
      for (r = 0; r < k; r++) begin
        for (c = 0; c < k; c++) begin
          cf = krow_reg[r][c2vr_pkg::CoefBits*c +: c2vr_pkg::CoefBits];
          acc += longint'(cf) * longint'(win[base+r][base+c]);
        end
      end
      // ReLU, drop the extra fraction bits, then saturate.
      if (acc <= 0) begin
        res.activation = '0;
      end else if ((acc >>> c2vr_pkg::FracBits) > c2vr_pkg::ActMax) begin
        res.activation = c2vr_pkg::ActBits'(c2vr_pkg::ActMax);
      end else begin
        res.activation = c2vr_pkg::ActBits'(acc >>> c2vr_pkg::FracBits);
      end
      res.last = (row + 1 == n) && (col + 1 == n);
      act_q.push_back(res);
    end

    col_cnt = col + 1;
    if (col_cnt >= n) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= n) row_cnt = 0;
    end
  endtask

  // Input side: hold an offered item until it is taken, otherwise maybe idle.
  always @(negedge clk_i) begin
    pix_item_t nxt;
    if (rst_ni && !(pix_if.valid && !pix_taken)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pixel_q.pop_front();
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= nxt.pixel;
        pix_if.frame_start <= nxt.frame_start;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Long output hold-off, started on request from the stimulus.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_left <= HoldCycles;
      hold_ack  <= hold_ack + 1;
    end
  end

  // Output side: random stalls, and ready held low throughout a hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      act_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Handshakes at the rising edge feed the predictor and the checks.
  always @(posedge clk_i) begin
    act_item_t want;
    if (!rst_ni) begin
      pix_taken = 1'b0;
    end else begin
      pix_taken = pix_if.valid && pix_if.ready;
      if (pix_taken) begin
        conv_step(pix_if.pixel, pix_if.frame_start);
        pix_accepted++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_cfg(c2vr_pkg::cfg_reg_e'(cfg_if.index), cfg_if.data);
      end
      if (act_if.valid && act_if.ready) begin
        if (act_q.size() == 0) begin
          report($sformatf("activation %0d with none expected", act_if.activation));
        end else begin
          want = act_q.pop_front();
          if (act_if.activation !== want.activation) begin
            report($sformatf("activation %0d, expected %0d",
                             act_if.activation, want.activation));
          end
          if (act_if.last_of_frame !== want.last) begin
            report($sformatf("last_of_frame %b, expected %b",
                             act_if.last_of_frame, want.last));
          end
        end
      end
    end
  end

  // Watchdog: too long without any item moving on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (act_if.valid && act_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic cfg_write(input c2vr_pkg::cfg_reg_e idx,
                           input logic [c2vr_pkg::CfgDataBits-1:0] d);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Wait until every pixel is taken and every activation has arrived, then
  // let the pipeline empty of items that produce nothing.
  task automatic drain();
    while (!(pix_accepted == pix_pushed && act_q.size() == 0)) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_pix(input c2vr_pkg::sample_t p, input logic fs);
    pix_item_t it;
    it.pixel       = p;
    it.frame_start = fs;
    pixel_q.push_back(it);
    pix_pushed++;
  endtask

  function automatic c2vr_pkg::sample_t rand_pixel();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return c2vr_pkg::sample_t'($urandom);
      default: return c2vr_pkg::sample_t'($urandom_range(2047)) - c2vr_pkg::sample_t'(1024);
    endcase
  endfunction

  function automatic logic [c2vr_pkg::KrowBits-1:0] rand_krow();
    logic [c2vr_pkg::KrowBits-1:0] v;
    for (int c = 0; c < c2vr_pkg::KregRows; c++) begin
      case ($urandom_range(7))
        0:       v[c2vr_pkg::CoefBits*c +: c2vr_pkg::CoefBits] = 16'h8000;
        1:       v[c2vr_pkg::CoefBits*c +: c2vr_pkg::CoefBits] = 16'h7FFF;
        2:       v[c2vr_pkg::CoefBits*c +: c2vr_pkg::CoefBits] = '0;
        3:       v[c2vr_pkg::CoefBits*c +: c2vr_pkg::CoefBits] =
                   c2vr_pkg::CoefBits'($urandom);
        default: v[c2vr_pkg::CoefBits*c +: c2vr_pkg::CoefBits] =
                   c2vr_pkg::CoefBits'($urandom_range(1023)) - 16'd512;
      endcase
    end
    return v;
  endfunction

  // Random pixels; the first carries first_fs, the rest a random frame start
  // when noisy.
  task automatic push_run(input int count, input logic first_fs, input bit noisy);
    for (int i = 0; i < count; i++) begin
      push_pix(rand_pixel(), (i == 0) ? first_fs : (noisy && $urandom_range(3) == 0));
    end
  endtask

  task automatic write_kernel_rows(input bit all_rows);
    for (int r = 0; r < c2vr_pkg::KregRows; r++) begin
      if (all_rows || $urandom_range(1) == 1) begin
        cfg_write(c2vr_pkg::cfg_reg_e'(c2vr_pkg::RegKernelRow0 + r), rand_krow());
      end
    end
  endtask

  initial begin
    int side, ks, n_eff, full, kind, cnt, nxt_side, start, round, pick;

    rst_ni             = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = c2vr_pkg::RegImageSize;
    cfg_if.data        = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel       = '0;
    pix_if.frame_start = 1'b0;
    act_if.ready       = 1'b0;

    // Predictor starts from the reset configuration and empty state.
    img_side_reg = c2vr_pkg::SizeBits'(28);
    krn_side_reg = c2vr_pkg::KsBits'(3);
    for (int r = 0; r < c2vr_pkg::KregRows; r++) krow_reg[r] = '0;
    for (int c = 0; c < c2vr_pkg::MaxWidth; c++) begin
      for (int r = 0; r < c2vr_pkg::LsRows; r++) line_mem[c][r] = '0;
    end
    for (int r = 0; r < c2vr_pkg::MaxKernel; r++) begin
      for (int c = 0; c < c2vr_pkg::MaxKernel; c++) win[r][c] = '0;
    end
    col_cnt = 0;
    row_cnt = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extreme pixels against extreme coefficients: saturation and ReLU.
    cfg_write(c2vr_pkg::RegImageSize, 3);
    cfg_write(c2vr_pkg::RegKernelSize, 2);
    cfg_write(c2vr_pkg::RegKernelRow0, 64'hFFFF_8000_7FFF_7FFF);
    cfg_write(c2vr_pkg::RegKernelRow1, 64'h7FFF_8000_0100_0100);
    cfg_write(c2vr_pkg::RegKernelRow2, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(c2vr_pkg::RegKernelRow3, 64'h0);
    push_pix(16'h7FFF, 1'b1);
    push_pix(16'h7FFF, 1'b0);
    push_pix(16'h8000, 1'b0);
    push_pix(16'h7FFF, 1'b0);
    push_pix(16'h7FFF, 1'b0);
    push_pix(16'h8000, 1'b0);
    push_pix(16'h0000, 1'b0);
    push_pix(16'h0001, 1'b0);
    push_pix(16'h8000, 1'b0);
    drain();

    // Zero sizes act as one; every pixel is a whole frame and overruns the last.
    cfg_write(c2vr_pkg::RegImageSize, 0);
    cfg_write(c2vr_pkg::RegKernelSize, 0);
    push_pix(16'h7FFF, 1'b1);
    push_pix(16'h8000, 1'b0);
    push_pix(16'h0100, 1'b0);
    drain();

    // Kernel wider than the image gives nothing.
    cfg_write(c2vr_pkg::RegImageSize, 2);
    cfg_write(c2vr_pkg::RegKernelSize, 7);
    push_run(4, 1'b1, 1'b0);
    drain();

    // Oversized and largest image sides with a single-tap kernel.
    cfg_write(c2vr_pkg::RegImageSize, 511);
    cfg_write(c2vr_pkg::RegKernelSize, 1);
    push_run(5, 1'b1, 1'b0);
    drain();
    cfg_write(c2vr_pkg::RegImageSize, 256);
    push_run(4, 1'b1, 1'b0);
    drain();

    // Output held off for a long stretch while frames keep streaming in.
    cfg_write(c2vr_pkg::RegImageSize, 12);
    cfg_write(c2vr_pkg::RegKernelSize, 2);
    write_kernel_rows(1'b1);
    push_run(144, 1'b1, 1'b0);
    push_run(144, 1'b1, 1'b0);
    hold_req++;
    drain();

    // Random rounds: mostly whole frames, some broken sequences and noise.
    start = pix_pushed;
    round = 0;
    while (pix_pushed - start < RandomItems) begin
      case (round % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 16; snk_stall_pct = 16; end
      endcase
      round++;

      pick = $urandom_range(99);
      if (pick < 5) side = $urandom_range(1);
      else if (pick < 80) side = $urandom_range(2, 8);
      else if (pick < 95) side = $urandom_range(9, 16);
      else side = $urandom_range(17, 511);
      pick = $urandom_range(99);
      if (pick < 10) ks = 0;
      else if (pick < 20) ks = $urandom_range(5, 7);
      else ks = $urandom_range(1, 4);
      cfg_write(c2vr_pkg::RegImageSize, side);
      cfg_write(c2vr_pkg::RegKernelSize, ks);
      write_kernel_rows(1'b0);

      n_eff = (side < 1) ? 1 : (side > c2vr_pkg::MaxWidth) ? c2vr_pkg::MaxWidth : side;
      full  = (n_eff <= 16) ? n_eff * n_eff : 2 * n_eff + $urandom_range(1, n_eff);
      kind  = $urandom_range(9);
      if (kind == 6 && n_eff >= 3 && n_eff <= 16) begin
        // The frame pauses, the side shrinks and the same frame goes on.
        push_run($urandom_range(n_eff, full - 1), 1'b1, 1'b0);
        drain();
        nxt_side = $urandom_range(1, n_eff - 1);
        cfg_write(c2vr_pkg::RegImageSize, nxt_side);
        push_run(nxt_side * nxt_side + $urandom_range(0, nxt_side), 1'b0, 1'b0);
      end else if (kind == 7) begin
        // A new frame starts before the current one is complete.
        push_run($urandom_range(1, full), 1'b1, 1'b0);
        push_run(full, 1'b1, 1'b0);
      end else if (kind == 8) begin
        // The frame overruns into the next one without a frame start.
        push_run(full, 1'b1, 1'b0);
        push_run($urandom_range(1, full), 1'b0, 1'b0);
      end else if (kind == 9) begin
        push_run($urandom_range(1, 30), 1'b1, 1'b1);
      end else begin
        cnt = $urandom_range(1, 2);
        for (int f = 0; f < cnt; f++) push_run(full, 1'b1, 1'b0);
      end
      drain();
    end

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
